// File: rtl/core/named_color_table_unit_macros.svh
// Assertion macros used by the named color table checker.
`ifndef NAMED_COLOR_TABLE_UNIT_MACROS_SVH
`define NAMED_COLOR_TABLE_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define NCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define NCT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/nct_pkg.sv
// Shared types and constants of the named color table.
package nct_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 80;
  localparam int COLOR_W     = 24;
  localparam int COUNT_OUT_W = 5;
  localparam logic [7:0] NAME_CHARS = 8'd10;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_DELETE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_APPEND
  } state_t;

endpackage

// File: rtl/core/nct_ram.sv
// Generic single write port, single read port RAM with registered read.
module nct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/nct_key_norm.sv
// Name key normalizer: zero every name byte after the first zero byte.
module nct_key_norm (
  input  logic [63:0]                name_low,
  input  logic [15:0]                name_high,
  output logic [nct_pkg::KEY_W-1:0]  key
);

  always_comb begin
    logic [nct_pkg::KEY_W-1:0] raw;
    logic [7:0]                ch;
    logic                      keep;
    raw  = {name_high, name_low};
    keep = 1'b1;
    key  = '0;
    for (int k = 0; k < nct_pkg::NAME_CHARS; k++) begin
      ch   = raw[8*k +: 8];
      keep = keep & (ch != 8'd0);
      key[8*k +: 8] = keep ? ch : 8'd0;
    end
  end

endmodule

// File: rtl/core/named_color_table_unit.sv
// Top level of the named color table: sequencer, shared key compare and entry RAM.
//
// Channel   Direction  Handshake                   Payload
// request   in         start high, busy low        mode, name_low, name_high, name_length,
//                                                  red_in, green_in, blue_in
// result    out        done strobe, one cycle      status, red_out, green_out, blue_out,
//                                                  stored_count
//
// Steps, accept to result: each scanned entry takes one RAM read (S_SCAN_RD) and one 80-bit
// key compare (S_SCAN_CMP). Add scans every stored entry, then appends in S_APPEND, or stops
// at a duplicate; look up stops at the hit or scans every entry on a miss; delete stops at
// the hit, then moves each later entry down a slot with S_SHIFT_RD and S_SHIFT_WR.
// Unused mode, full table, long name, and look up or delete on an empty table finish in idle.
// The entry RAM port sets the pace.
// Reset: rst clears the sequencer, the entry count and the strobe; no clearing pass,
// since only slots below the count are ever used.
// Stalls: none on the result side; busy holds off requests until the result is shown.
module named_color_table_unit #(
  parameter int ENTRIES = nct_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [63:0] name_low,
  input  logic [15:0] name_high,
  input  logic [7:0]  name_length,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic [4:0]  stored_count
);

  // Slot index and entry count widths.
  localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int RAM_W = nct_pkg::KEY_W + nct_pkg::COLOR_W;

  nct_pkg::state_t state, state_next;

  // Request held for the whole operation.
  logic [1:0]                  req_mode;
  logic [nct_pkg::KEY_W-1:0]   req_key;
  logic [nct_pkg::COLOR_W-1:0] req_color;

  logic [AW-1:0] idx, idx_next;
  logic [CW-1:0] count, count_next;

  logic [nct_pkg::KEY_W-1:0] in_key;
  logic                      accept;

  // RAM port signals.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [RAM_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [RAM_W-1:0] ram_rdata;

  // Completion of the current request.
  logic                        finish;
  nct_pkg::status_t            fin_status;
  logic [nct_pkg::COLOR_W-1:0] fin_color;

  // Shared compare unit and scan bounds.
  logic          key_hit;
  logic [CW:0]   idx_p1;
  logic [CW:0]   idx_p2;
  logic [CW:0]   count_ext;

  assign busy      = (state != nct_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign key_hit   = (ram_rdata[RAM_W-1 -: nct_pkg::KEY_W] == req_key);
  assign idx_p1    = (CW+1)'(idx) + (CW+1)'(1);
  assign idx_p2    = (CW+1)'(idx) + (CW+1)'(2);
  assign count_ext = (CW+1)'(count);

  nct_key_norm u_key_norm (
    .name_low  (name_low),
    .name_high (name_high),
    .key       (in_key)
  );

  nct_ram #(
    .WIDTH (RAM_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nct_pkg::S_IDLE;
      count <= '0;
      idx   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      done  <= finish;
    end
  end

  // Capture the request and the result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode  <= mode;
      req_key   <= in_key;
      req_color <= {red_in, green_in, blue_in};
    end
    if (finish) begin
      status       <= fin_status;
      red_out      <= fin_color[23:16];
      green_out    <= fin_color[15:8];
      blue_out     <= fin_color[7:0];
      stored_count <= nct_pkg::COUNT_OUT_W'(count_next);
    end
  end

  // Sequencer: scan, shift down and append over the entry RAM's one read and one write port.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    count_next = count;
    finish     = 1'b0;
    fin_status = nct_pkg::ST_OK;
    fin_color  = '0;
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wdata  = ram_rdata;
    ram_raddr  = idx;

    unique case (state)
      nct_pkg::S_IDLE: begin
        if (accept) begin
          idx_next = '0;
          case (mode)
            nct_pkg::MODE_ADD: begin
              if (count >= CW'(ENTRIES)) begin
                finish     = 1'b1;
                fin_status = nct_pkg::ST_FULL;
              end else if (name_length > nct_pkg::NAME_CHARS) begin
                finish     = 1'b1;
                fin_status = nct_pkg::ST_TOO_LONG;
              end else if (count == '0) begin
                state_next = nct_pkg::S_APPEND;
              end else begin
                state_next = nct_pkg::S_SCAN_RD;
              end
            end
            nct_pkg::MODE_LOOKUP, nct_pkg::MODE_DELETE: begin
              if (count == '0) begin
                finish     = 1'b1;
                fin_status = nct_pkg::ST_NOT_FOUND;
              end else begin
                state_next = nct_pkg::S_SCAN_RD;
              end
            end
            default: begin
              // Unused mode: report ok and leave the table alone.
              finish = 1'b1;
            end
          endcase
        end
      end

      nct_pkg::S_SCAN_RD: begin
        ram_raddr  = idx;
        state_next = nct_pkg::S_SCAN_CMP;
      end

      nct_pkg::S_SCAN_CMP: begin
        if (key_hit) begin
          case (req_mode)
            nct_pkg::MODE_ADD: begin
              finish     = 1'b1;
              fin_status = nct_pkg::ST_DUPLICATE;
              state_next = nct_pkg::S_IDLE;
            end
            nct_pkg::MODE_LOOKUP: begin
              finish     = 1'b1;
              fin_color  = ram_rdata[nct_pkg::COLOR_W-1:0];
              state_next = nct_pkg::S_IDLE;
            end
            default: begin
              // Delete: move later entries down, or drop the last one directly.
              if (idx_p1 < count_ext) begin
                state_next = nct_pkg::S_SHIFT_RD;
              end else begin
                count_next = count - CW'(1);
                finish     = 1'b1;
                state_next = nct_pkg::S_IDLE;
              end
            end
          endcase
        end else if (idx_p1 < count_ext) begin
          idx_next   = idx_p1[AW-1:0];
          state_next = nct_pkg::S_SCAN_RD;
        end else if (req_mode == nct_pkg::MODE_ADD) begin
          state_next = nct_pkg::S_APPEND;
        end else begin
          finish     = 1'b1;
          fin_status = nct_pkg::ST_NOT_FOUND;
          state_next = nct_pkg::S_IDLE;
        end
      end

      nct_pkg::S_SHIFT_RD: begin
        ram_raddr  = idx_p1[AW-1:0];
        state_next = nct_pkg::S_SHIFT_WR;
      end

      nct_pkg::S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
        idx_next  = idx_p1[AW-1:0];
        if (idx_p2 < count_ext) begin
          state_next = nct_pkg::S_SHIFT_RD;
        end else begin
          count_next = count - CW'(1);
          finish     = 1'b1;
          state_next = nct_pkg::S_IDLE;
        end
      end

      nct_pkg::S_APPEND: begin
        ram_we     = 1'b1;
        ram_waddr  = count[AW-1:0];
        ram_wdata  = {req_key, req_color};
        count_next = count + CW'(1);
        finish     = 1'b1;
        state_next = nct_pkg::S_IDLE;
      end

      default: begin
        state_next = nct_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/nct_checker.sv
// Port-level checker of the named color table, bound to the top level.
`include "named_color_table_unit_macros.svh"

module nct_checker #(
  parameter int ENTRIES = nct_pkg::ENTRIES_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic [7:0]  red_out,
  input logic [7:0]  green_out,
  input logic [7:0]  blue_out,
  input logic [4:0]  stored_count
);

  `NCT_ASSERT(a_accept_progress, start && !busy |=> busy || done, "request lost after accept")
  `NCT_ASSERT(a_done_when_idle, done |-> !busy, "result shown while still busy")
  `NCT_ASSERT(a_color_only_ok, done && status != nct_pkg::ST_OK |-> red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0, "color on failed request")
  `NCT_ASSERT(a_full_count, done && status == nct_pkg::ST_FULL |-> stored_count == 5'(ENTRIES), "full status with table not full")
  `NCT_ASSERT_ALWAYS(a_reset_quiet, rst |=> !done && !busy, "reset did not clear sequencer")

endmodule

bind named_color_table_unit nct_checker #(.ENTRIES(ENTRIES)) u_nct_checker (.*);

// File: verif/tb_top.sv
// Self-checking testbench for the named color table: directed table, then random requests.
module tb_top;

  localparam int         TABLE_DEPTH = nct_pkg::ENTRIES_DEF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         RANDOM_REQS = 1600;
  localparam int         CALM_TAIL   = 200;   // last random requests, sent without gaps
  localparam int         DRAIN_WAIT  = 80;    // watch for stray strobes after the last reply
  localparam int         DIR_ROWS    = 20;

  typedef struct packed {
    nct_pkg::status_t st;
    logic [23:0]      rgb;
    logic [4:0]       cnt;
  } reply_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [79:0]      key;
    logic [7:0]       len;
    logic [23:0]      rgb;
    bit               typed;
    nct_pkg::status_t st;
    logic [23:0]      rgb_out;
    logic [4:0]       cnt;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode = '0;
  logic [63:0] name_low = '0;
  logic [15:0] name_high = '0;
  logic [7:0]  name_length = '0;
  logic [7:0]  red_in = '0;
  logic [7:0]  green_in = '0;
  logic [7:0]  blue_in = '0;
  logic        done;
  logic [2:0]  status;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [4:0]  stored_count;

  // Mirror of the table contents, kept in step with every accepted request.
  logic [79:0] held_key [TABLE_DEPTH];
  logic [23:0] held_rgb [TABLE_DEPTH];
  int          held_count = 0;

  reply_t      replies_due [$];
  logic [79:0] name_pool [32];
  dir_row_t    dir_table [DIR_ROWS];
  int          fault_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  named_color_table_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .name_low(name_low), .name_high(name_high), .name_length(name_length),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .done(done), .status(status), .red_out(red_out), .green_out(green_out),
    .blue_out(blue_out), .stored_count(stored_count)
  );

  // Count the characters ahead of the first zero byte.
  function automatic int name_chars_used(input logic [79:0] key);
    int n;
    bit cut;
    n = 0;
    cut = 1'b0;
    for (int k = 0; k < 10; k++) begin
      if (key[8*k +: 8] == 8'h00) cut = 1'b1;
      if (!cut) n++;
    end
    return n;
  endfunction

  // Zero every byte from the first zero byte on, so equal strings give equal keys.
  function automatic logic [79:0] key_canon(input logic [79:0] key);
    bit cut;
    cut = 1'b0;
    for (int k = 0; k < 10; k++) begin
      if (key[8*k +: 8] == 8'h00) cut = 1'b1;
      if (cut) key[8*k +: 8] = 8'h00;
    end
    return key;
  endfunction

  // Apply one request to the mirrored table and return the reply it should give.
  task automatic color_table_apply(input logic [1:0] op, input logic [79:0] raw_key,
                                   input logic [7:0] len, input logic [23:0] rgb,
                                   output reply_t reply);
    logic [79:0] key;
    int hit;
    key = key_canon(raw_key);
    hit = -1;
    for (int i = 0; i < held_count; i++)
      if (hit < 0 && held_key[i] == key) hit = i;
    reply.st  = nct_pkg::ST_OK;
    reply.rgb = '0;
    case (op)
      nct_pkg::MODE_ADD: begin
        if (held_count >= TABLE_DEPTH) reply.st = nct_pkg::ST_FULL;
        else if (len > nct_pkg::NAME_CHARS) reply.st = nct_pkg::ST_TOO_LONG;
        else if (hit >= 0) reply.st = nct_pkg::ST_DUPLICATE;
        else begin
          held_key[held_count] = key;
          held_rgb[held_count] = rgb;
          held_count++;
        end
      end
      nct_pkg::MODE_LOOKUP: begin
        if (hit < 0) reply.st = nct_pkg::ST_NOT_FOUND;
        else reply.rgb = held_rgb[hit];
      end
      nct_pkg::MODE_DELETE: begin
        if (hit < 0) reply.st = nct_pkg::ST_NOT_FOUND;
        else begin
          // Close the gap: move every later entry down one slot.
          for (int i = hit + 1; i < held_count; i++) begin
            held_key[i-1] = held_key[i];
            held_rgb[i-1] = held_rgb[i];
          end
          held_count--;
        end
      end
      default: ;
    endcase
    reply.cnt = held_count[4:0];
  endtask

  // Pick a name: a stored one, a pool one or pure noise; maybe junk after the terminator.
  function automatic logic [79:0] pick_name(input bit from_table);
    logic [79:0] key;
    int n;
    if (from_table && held_count > 0)
      key = held_key[$urandom_range(0, held_count - 1)];
    else if ($urandom_range(0, 9) == 0)
      key = {$urandom, $urandom, 16'($urandom)};
    else
      key = name_pool[$urandom_range(0, 31)];
    n = name_chars_used(key);
    if (n < 10 && $urandom_range(0, 1) == 1)
      for (int k = n + 1; k < 10; k++) key[8*k +: 8] = 8'($urandom);
    return key;
  endfunction

  // Present one request from a falling edge, hold it until accepted, log its reply.
  // Enter and leave at a falling edge.
  task automatic issue_request(input logic [1:0] op, input logic [79:0] key,
                               input logic [7:0] len, input logic [23:0] rgb,
                               input bit typed, input reply_t typed_reply,
                               input bit allow_gap);
    reply_t pred;
    if (allow_gap && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start       <= 1'b1;
    mode        <= op;
    name_low    <= key[63:0];
    name_high   <= key[79:64];
    name_length <= len;
    red_in      <= rgb[23:16];
    green_in    <= rgb[15:8];
    blue_in     <= rgb[7:0];
    // Hold the request until an edge sees busy low.
    do @(posedge clk); while (busy !== 1'b0);
    color_table_apply(op, key, len, rgb, pred);
    replies_due.push_back(typed ? typed_reply : pred);
    @(negedge clk);
  endtask

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fault_count++;
    end
  endfunction

  // Match every strobed reply against the oldest outstanding one.
  always @(posedge clk) begin
    reply_t want;
    if (!rst && done === 1'b1) begin
      if (replies_due.size() == 0) begin
        $display("%0t: reply with none outstanding, expected none, actual status %0d",
                 $time, status);
        fault_count++;
      end else begin
        want = replies_due.pop_front();
        if ({status, red_out, green_out, blue_out, stored_count} !==
            {want.st, want.rgb, want.cnt}) begin
          check_field("status", want.st, status);
          check_field("red_out", want.rgb[23:16], red_out);
          check_field("green_out", want.rgb[15:8], green_out);
          check_field("blue_out", want.rgb[7:0], blue_out);
          check_field("stored_count", want.cnt, stored_count);
          // Catch X or Z that the integer compare above folds away.
          if (^{status, red_out, green_out, blue_out, stored_count} === 1'bx) begin
            $display("%0t: reply carries unknown bits, expected %h, actual %h", $time,
                     {want.st, want.rgb, want.cnt},
                     {status, red_out, green_out, blue_out, stored_count});
            fault_count++;
          end
        end
      end
    end
  end

  initial begin
    reply_t      typed_reply;
    logic [1:0]  op;
    logic [79:0] key;
    logic [7:0]  len;
    int          pick;
    int          n;
    bit          filling;
    bit          gappy;

    // Directed table. Names are little-endian: character 0 sits in the low byte.
    // Typed rows carry their expected reply; the rest go through the predictor.
    dir_table = '{
      // look up and delete on an empty table miss
      '{nct_pkg::MODE_LOOKUP, 80'h0000_0000_0000_0044_4552, 8'd3, 24'h0, 1'b1,
        nct_pkg::ST_NOT_FOUND, 24'h0, 5'd0},
      '{nct_pkg::MODE_DELETE, 80'h0000_0000_0000_0044_4552, 8'd3, 24'h0, 1'b1,
        nct_pkg::ST_NOT_FOUND, 24'h0, 5'd0},
      // unused mode does nothing
      '{MODE_UNUSED, 80'hFFFF_FFFF_FFFF_FFFF_FFFF, 8'd255, 24'hFFFFFF, 1'b1,
        nct_pkg::ST_OK, 24'h0, 5'd0},
      // empty name is a valid key
      '{nct_pkg::MODE_ADD, 80'h0, 8'd0, 24'hFFFFFF, 1'b1,
        nct_pkg::ST_OK, 24'h0, 5'd1},
      '{nct_pkg::MODE_ADD, 80'h0000_0000_0000_0044_4552, 8'd3, 24'hFF0000, 1'b1,
        nct_pkg::ST_OK, 24'h0, 5'd2},
      // junk after the terminator still matches the stored name
      '{nct_pkg::MODE_ADD, 80'h5A5A_A5A5_A5A5_0044_4552, 8'd3, 24'h00FF00, 1'b1,
        nct_pkg::ST_DUPLICATE, 24'h0, 5'd2},
      // over-long name is reported ahead of the duplicate
      '{nct_pkg::MODE_ADD, 80'h0000_0000_0000_0044_4552, 8'd11, 24'h0, 1'b1,
        nct_pkg::ST_TOO_LONG, 24'h0, 5'd2},
      '{nct_pkg::MODE_ADD, 80'h4A49_4847_4645_4443_4241, 8'd255, 24'h0, 1'b1,
        nct_pkg::ST_TOO_LONG, 24'h0, 5'd2},
      // full ten-character names fit
      '{nct_pkg::MODE_ADD, 80'hFFFF_FFFF_FFFF_FFFF_FFFF, 8'd10, 24'h000000, 1'b1,
        nct_pkg::ST_OK, 24'h0, 5'd3},
      '{nct_pkg::MODE_ADD, 80'h4A49_4847_4645_4443_4241, 8'd10, 24'h123456, 1'b1,
        nct_pkg::ST_OK, 24'h0, 5'd4},
      '{nct_pkg::MODE_LOOKUP, 80'hFFFF_FFFF_FFFF_FFFF_FFFF, 8'd0, 24'h0, 1'b0,
        nct_pkg::ST_OK, 24'h0, 5'd0},
      '{nct_pkg::MODE_LOOKUP, 80'h5A5A_A5A5_A5A5_0044_4552, 8'd3, 24'hABCDEF, 1'b0,
        nct_pkg::ST_OK, 24'h0, 5'd0},
      '{nct_pkg::MODE_LOOKUP, 80'hFFFF_FFFF_FFFF_FFFF_FF00, 8'd0, 24'h0, 1'b0,
        nct_pkg::ST_OK, 24'h0, 5'd0},
      '{nct_pkg::MODE_LOOKUP, 80'h0000_0000_0000_5844_4552, 8'd4, 24'h0, 1'b0,
        nct_pkg::ST_OK, 24'h0, 5'd0},
      // delete from the middle, then find an entry that moved down
      '{nct_pkg::MODE_DELETE, 80'h0000_0000_0000_0044_4552, 8'd3, 24'h0, 1'b0,
        nct_pkg::ST_OK, 24'h0, 5'd0},
      '{nct_pkg::MODE_LOOKUP, 80'h4A49_4847_4645_4443_4241, 8'd10, 24'h0, 1'b0,
        nct_pkg::ST_OK, 24'h0, 5'd0},
      '{nct_pkg::MODE_DELETE, 80'h0, 8'd0, 24'h0, 1'b0,
        nct_pkg::ST_OK, 24'h0, 5'd0},
      '{nct_pkg::MODE_ADD, 80'h0049_4847_4645_4443_4241, 8'd9, 24'hFEDCBA, 1'b0,
        nct_pkg::ST_OK, 24'h0, 5'd0},
      // names that differ only in the last character must not match
      '{nct_pkg::MODE_LOOKUP, 80'h4B49_4847_4645_4443_4241, 8'd10, 24'h0, 1'b0,
        nct_pkg::ST_OK, 24'h0, 5'd0},
      '{nct_pkg::MODE_DELETE, 80'hFFFF_FFFF_FFFF_FFFF_FFFF, 8'd10, 24'h0, 1'b0,
        nct_pkg::ST_OK, 24'h0, 5'd0}
    };

    // Build a pool of names of every length so adds collide and look ups hit.
    foreach (name_pool[p]) begin
      name_pool[p] = '0;
      n = (p == 0) ? 0 : $urandom_range(0, 10);
      for (int k = 0; k < n; k++) name_pool[p][8*k +: 8] = 8'($urandom_range(1, 255));
    end

    // Hold reset, then release it at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_table[r]) begin
      typed_reply.st  = dir_table[r].st;
      typed_reply.rgb = dir_table[r].rgb_out;
      typed_reply.cnt = dir_table[r].cnt;
      issue_request(dir_table[r].op, dir_table[r].key, dir_table[r].len, dir_table[r].rgb,
                    dir_table[r].typed, typed_reply, 1'b1);
    end

    // Random part: swing the table between empty and full so every slot sees adds,
    // look ups and deletes; adds can meet the full table at the top of each swing.
    filling = 1'b1;
    typed_reply = '0;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (held_count >= TABLE_DEPTH) filling = 1'b0;
      if (held_count == 0) filling = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 3) op = MODE_UNUSED;
      else if (filling)
        op = (pick < 60) ? nct_pkg::MODE_ADD :
             (pick < 82) ? nct_pkg::MODE_LOOKUP : nct_pkg::MODE_DELETE;
      else
        op = (pick < 15) ? nct_pkg::MODE_ADD :
             (pick < 55) ? nct_pkg::MODE_LOOKUP : nct_pkg::MODE_DELETE;

      if (op == nct_pkg::MODE_ADD) key = pick_name($urandom_range(0, 9) == 0);
      else key = pick_name($urandom_range(0, 9) < 7);

      // Mostly an honest length for adds; sometimes over the limit or arbitrary.
      pick = $urandom_range(0, 99);
      if (op != nct_pkg::MODE_ADD || pick < 5) len = 8'($urandom);
      else if (pick < 15) len = 8'($urandom_range(11, 255));
      else len = 8'(name_chars_used(key));

      // Alternate stretches with idle bursts and stretches without; drop gaps at the end.
      gappy = ((i / 150) % 3 != 2) && (i < RANDOM_REQS - CALM_TAIL);
      issue_request(op, key, len, 24'($urandom), 1'b0, typed_reply, gappy);
    end
    start <= 1'b0;

    // Drain outstanding replies, then watch for stray strobes.
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fault_count == 0 && replies_due.size() == 0)
      $display("named_color_table_unit test passed");
    else
      $display("named_color_table_unit test failed");
    $finish;
  end

  // Abort a hung run: far beyond the slowest legal run of every request.
  initial begin
    #2_000_000;
    $display("named_color_table_unit test failed");
    $finish;
  end

endmodule

// File: named_color_table_unit.f
+incdir+rtl/core
rtl/core/nct_pkg.sv
rtl/core/nct_ram.sv
rtl/core/nct_key_norm.sv
rtl/core/named_color_table_unit.sv
rtl/core/nct_checker.sv
verif/tb_top.sv
